FILE: rtl/dqb_pkg.sv
// Shared types, constants and byte tables for the DNS query builder.
`timescale 1ns / 1ps

package dqb_pkg;

  localparam logic [7:0] DOT_CHAR       = 8'h2E;
  localparam logic [15:0] QCLASS_INET   = 16'd1;
  localparam logic [15:0] QTYPE_RST     = 16'd1;
  localparam int unsigned HDR_BYTES     = 12;
  localparam int unsigned TRAIL_BYTES   = 5;

  // Configuration register indexes
  localparam logic CFG_QUERY_ID = 1'b0;
  localparam logic CFG_QTYPE    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_LEN,
    ST_DATA,
    ST_TRAIL
  } seq_state_t;

  // Header: ID, flags 0x0100 (RD), QDCOUNT 1, three zero counts.
  function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] qid);
    logic [7:0] b;
    case (idx)
      4'd0:    b = qid[15:8];
      4'd1:    b = qid[7:0];
      4'd2:    b = 8'h01;
      4'd5:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Trailer: root terminator, QTYPE, QCLASS.
  function automatic logic [7:0] trail_byte(input logic [2:0] idx, input logic [15:0] qtype);
    logic [7:0] b;
    case (idx)
      3'd1:    b = qtype[15:8];
      3'd2:    b = qtype[7:0];
      3'd3:    b = QCLASS_INET[15:8];
      3'd4:    b = QCLASS_INET[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/dqb_label_mem.sv
// Label byte store: one write port, one registered read port.
`timescale 1ns / 1ps

module dqb_label_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/dqb_seq.sv
// Message sequencer: label bookkeeping, header/label/trailer emission, output register.
`timescale 1ns / 1ps

module dqb_seq #(
  parameter int MAX_LABEL = 32,
  parameter int AW        = 5,
  parameter int LW        = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_name_char,
  input  logic          in_name_end,
  input  logic [15:0]   query_id,
  input  logic [15:0]   qtype,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [7:0]    mem_wdata,
  output logic          mem_re,
  output logic [AW-1:0] mem_raddr,
  input  logic [7:0]    mem_rdata,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_packet_last,
  output logic          out_label_too_long
);

  localparam int CW = (LW > 4) ? LW : 4;

  dqb_pkg::seq_state_t state_r, state_nxt;
  logic          in_message_r, in_message_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          ovf_r, ovf_nxt;
  logic          dot_r, dot_nxt;
  logic          end_r, end_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic          ov_r;
  logic [7:0]    ob_r;
  logic          olast_r;
  logic          otl_r;

  logic          accept;
  logic          in_dot;
  logic          has_room;
  logic          out_free;
  logic          emit;
  logic [7:0]    emit_byte;
  logic          emit_last;
  logic          emit_tl;
  logic [CW-1:0] len_ext;
  logic [CW-1:0] cnt_inc;

  assign in_ready = (state_r == dqb_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_dot   = (in_name_char == dqb_pkg::DOT_CHAR);
  assign has_room = (len_r < LW'(MAX_LABEL));
  assign out_free = !ov_r || out_ready;
  assign emit     = (state_r != dqb_pkg::ST_IDLE) && out_free;
  assign len_ext  = CW'(len_r);
  assign cnt_inc  = cnt_r + CW'(1);

  // Next state and bookkeeping
  always_comb begin
    state_nxt      = state_r;
    in_message_nxt = in_message_r;
    len_nxt        = len_r;
    ovf_nxt        = ovf_r;
    dot_nxt        = dot_r;
    end_nxt        = end_r;
    cnt_nxt        = cnt_r;
    case (state_r)
      dqb_pkg::ST_IDLE: begin
        if (accept) begin
          in_message_nxt = !in_name_end;
          dot_nxt        = in_dot;
          end_nxt        = in_name_end;
          cnt_nxt        = '0;
          if (!in_dot) begin
            if (has_room) begin
              len_nxt = len_r + LW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (!in_message_r) begin
            state_nxt = dqb_pkg::ST_HDR;
          end else if (in_dot || in_name_end) begin
            state_nxt = dqb_pkg::ST_LEN;
          end
        end
      end
      dqb_pkg::ST_HDR: begin
        if (emit) begin
          cnt_nxt = cnt_inc;
          if (cnt_r == CW'(dqb_pkg::HDR_BYTES - 1)) begin
            cnt_nxt   = '0;
            state_nxt = (dot_r || end_r) ? dqb_pkg::ST_LEN : dqb_pkg::ST_IDLE;
          end
        end
      end
      dqb_pkg::ST_LEN: begin
        if (emit) begin
          cnt_nxt = '0;
          if (len_r == '0) begin
            ovf_nxt   = 1'b0;
            state_nxt = end_r ? dqb_pkg::ST_TRAIL : dqb_pkg::ST_IDLE;
          end else begin
            state_nxt = dqb_pkg::ST_DATA;
          end
        end
      end
      dqb_pkg::ST_DATA: begin
        if (emit) begin
          cnt_nxt = cnt_inc;
          if (cnt_inc == len_ext) begin
            cnt_nxt   = '0;
            len_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = end_r ? dqb_pkg::ST_TRAIL : dqb_pkg::ST_IDLE;
          end
        end
      end
      dqb_pkg::ST_TRAIL: begin
        if (emit) begin
          cnt_nxt = cnt_inc;
          if (cnt_r == CW'(dqb_pkg::TRAIL_BYTES - 1)) begin
            cnt_nxt   = '0;
            state_nxt = dqb_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = dqb_pkg::ST_IDLE;
      end
    endcase
  end

  // Emitted byte and memory accesses
  always_comb begin
    emit_byte = 8'h00;
    emit_last = 1'b0;
    emit_tl   = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = accept && !in_dot && has_room;
    mem_waddr = len_r[AW-1:0];
    mem_wdata = in_name_char;
    case (state_r)
      dqb_pkg::ST_HDR: begin
        emit_byte = dqb_pkg::hdr_byte(cnt_r[3:0], query_id);
      end
      dqb_pkg::ST_LEN: begin
        emit_byte = 8'(len_r);
        emit_tl   = ovf_r;
        // prefetch the first label byte
        mem_re    = emit && (len_r != '0);
      end
      dqb_pkg::ST_DATA: begin
        emit_byte = mem_rdata;
        mem_re    = emit && (cnt_inc < len_ext);
        mem_raddr = cnt_inc[AW-1:0];
      end
      dqb_pkg::ST_TRAIL: begin
        emit_byte = dqb_pkg::trail_byte(cnt_r[2:0], qtype);
        emit_last = (cnt_r == CW'(dqb_pkg::TRAIL_BYTES - 1));
      end
      default: begin
        emit_byte = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dqb_pkg::ST_IDLE;
      in_message_r <= 1'b0;
      len_r        <= '0;
      ovf_r        <= 1'b0;
      dot_r        <= 1'b0;
      end_r        <= 1'b0;
      cnt_r        <= '0;
      ov_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_message_r <= in_message_nxt;
      len_r        <= len_nxt;
      ovf_r        <= ovf_nxt;
      dot_r        <= dot_nxt;
      end_r        <= end_nxt;
      cnt_r        <= cnt_nxt;
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Output register payload; hold while the beat is stalled
  always_ff @(posedge clk) begin
    if (emit) begin
      ob_r    <= emit_byte;
      olast_r <= emit_last;
      otl_r   <= emit_tl;
    end
  end

  assign out_valid          = ov_r;
  assign out_byte           = ob_r;
  assign out_packet_last    = olast_r;
  assign out_label_too_long = otl_r;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(MAX_LABEL))
    else $error("label length beyond MAX_LABEL");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (len_r == LW'(MAX_LABEL)))
    else $error("overflow flagged on a label that is not full");

  a_tl_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_label_too_long) |-> (out_byte == 8'(MAX_LABEL)))
    else $error("truncation flag on a byte other than a full length byte");

  a_last_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_last) |=> (!in_message_r && len_r == '0 && !ovf_r))
    else $error("message closed with name state left open");
`endif

endmodule

FILE: rtl/dns_query_builder_unit.sv
// Top level of the DNS query builder: configuration registers, sequencer and label store.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready): one name character per beat, with
//   in_name_end marking the last character of the dotted name.
//   Output channel (out_valid/out_ready): one message byte per beat in wire
//   order; out_packet_last flags the low class byte, out_label_too_long a
//   length byte whose label was cut at MAX_LABEL characters.
//   Configuration: cfg_we writes cfg_wdata into query_id (index 0) or the
//   record type (index 1); write only while no message bytes are pending.
// Timing:
//   A character that neither opens a name nor closes a label emits no bytes.
//   The first character of a name adds the header, a dot or the last character
//   adds the length byte and the label bytes, and the last character adds the
//   trailer; the sequencer emits one byte per cycle into the output register
//   while it is free, and takes the next character once the item is fully emitted.
//   Label bytes come back from the label store in the cycle after their read.
//   A stalled receiver holds the output beat and freezes the sequencer.
// Reset: synchronous rst_n returns to idle with no header sent, an empty label,
//   query_id 0 and record type 1; the label store needs no clearing.

module dns_query_builder_unit #(
  parameter int MAX_LABEL = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_name_char,
  input  logic        in_name_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_packet_last,
  output logic        out_label_too_long,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam int LW = $clog2(MAX_LABEL + 1);

  logic [15:0]   query_id_r;
  logic [15:0]   qtype_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_id_r <= '0;
      qtype_r    <= dqb_pkg::QTYPE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dqb_pkg::CFG_QUERY_ID: query_id_r <= cfg_wdata;
        dqb_pkg::CFG_QTYPE:    qtype_r    <= cfg_wdata;
        default: begin
          query_id_r <= query_id_r;
        end
      endcase
    end
  end

  dqb_label_mem #(
    .DEPTH (MAX_LABEL),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dqb_seq #(
    .MAX_LABEL (MAX_LABEL),
    .AW        (AW),
    .LW        (LW)
  ) u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_name_char       (in_name_char),
    .in_name_end        (in_name_end),
    .query_id           (query_id_r),
    .qtype              (qtype_r),
    .mem_we             (mem_we),
    .mem_waddr          (mem_waddr),
    .mem_wdata          (mem_wdata),
    .mem_re             (mem_re),
    .mem_raddr          (mem_raddr),
    .mem_rdata          (mem_rdata),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_packet_last    (out_packet_last),
    .out_label_too_long (out_label_too_long)
  );

endmodule

FILE: test/dns_query_builder_unit_checker.sv
// Byte-stream checker for the DNS query builder: predicts every message byte and compares.
`timescale 1ns / 1ps

module dns_query_builder_unit_checker #(
  parameter int MAX_LABEL = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_name_char,
  input  logic        in_name_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        out_packet_last,
  input  logic        out_label_too_long,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          error_count,
  output int          bytes_pending,
  output int          bytes_checked,
  output int          labels_cut
);

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       cut;
  } msg_byte_t;

  msg_byte_t   wire_bytes_q[$];
  logic [15:0] query_id_shadow;
  logic [15:0] qtype_shadow;
  logic        msg_open;
  logic [7:0]  label_buf[MAX_LABEL];
  int          label_len;
  logic        label_trunc;

  function automatic void emit(input logic [7:0] v, input logic last, input logic cut);
    msg_byte_t b;
    b.value = v;
    b.last  = last;
    b.cut   = cut;
    wire_bytes_q.push_back(b);
  endfunction

  // Length byte, then the kept characters of the open label.
  function automatic void close_label();
    emit(8'(label_len), 1'b0, label_trunc);
    if (label_trunc) labels_cut++;
    for (int i = 0; i < label_len; i++) emit(label_buf[i], 1'b0, 1'b0);
    label_len   = 0;
    label_trunc = 1'b0;
  endfunction

  function automatic void encode_char(input logic [7:0] ch, input logic name_last);
    if (!msg_open) begin
      emit(query_id_shadow[15:8], 1'b0, 1'b0);
      emit(query_id_shadow[7:0], 1'b0, 1'b0);
      // flags 0x0100 (RD), QDCOUNT 1, three zero counts
      for (int i = 2; i < 12; i++) emit((i == 2 || i == 5) ? 8'h01 : 8'h00, 1'b0, 1'b0);
      msg_open = 1'b1;
    end
    if (ch == dqb_pkg::DOT_CHAR) begin
      close_label();
    end else begin
      if (label_len < MAX_LABEL) begin
        label_buf[label_len] = ch;
        label_len++;
      end else begin
        label_trunc = 1'b1;
      end
      if (name_last) close_label();
    end
    if (name_last) begin
      emit(8'h00, 1'b0, 1'b0);
      emit(qtype_shadow[15:8], 1'b0, 1'b0);
      emit(qtype_shadow[7:0], 1'b0, 1'b0);
      emit(dqb_pkg::QCLASS_INET[15:8], 1'b0, 1'b0);
      emit(dqb_pkg::QCLASS_INET[7:0], 1'b1, 1'b0);
      msg_open    = 1'b0;
      label_len   = 0;
      label_trunc = 1'b0;
    end
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want_v,
                                      input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", field, want_v, got_v);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    msg_byte_t want;
    if (!rst_n) begin
      wire_bytes_q.delete();
      query_id_shadow = 16'd0;
      qtype_shadow    = dqb_pkg::QTYPE_RST;
      msg_open        = 1'b0;
      label_len       = 0;
      label_trunc     = 1'b0;
      error_count     = 0;
      bytes_checked   = 0;
      labels_cut      = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (wire_bytes_q.size() == 0) begin
          $error("out beat with nothing expected: byte %0h", out_byte);
          error_count++;
        end else begin
          want = wire_bytes_q.pop_front();
          check_field("out_byte", want.value, out_byte);
          check_field("out_packet_last", 8'(want.last), 8'(out_packet_last));
          check_field("out_label_too_long", 8'(want.cut), 8'(out_label_too_long));
          bytes_checked++;
        end
      end
      if (in_valid && in_ready) encode_char(in_name_char, in_name_end);
      if (cfg_we) begin
        if (cfg_index == dqb_pkg::CFG_QUERY_ID) query_id_shadow = cfg_wdata;
        else qtype_shadow = cfg_wdata;
      end
    end
    bytes_pending = wire_bytes_q.size();
  end

endmodule

FILE: test/dns_query_builder_unit_tb.sv
// Testbench top for the DNS query builder: stimulus, idling phases and the verdict.
`timescale 1ns / 1ps

module dns_query_builder_unit_tb;

  localparam int MAX_LABEL = 32;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_name_char;
  logic        in_name_end;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_packet_last;
  logic        out_label_too_long;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  int error_count;
  int bytes_pending;
  int bytes_checked;
  int labels_cut;
  int send_idle_pct;
  int recv_stall_pct;
  int chars_sent;
  int names_sent;

  logic [7:0] name_q[$];

  dns_query_builder_unit #(.MAX_LABEL(MAX_LABEL)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_name_char       (in_name_char),
    .in_name_end        (in_name_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_packet_last    (out_packet_last),
    .out_label_too_long (out_label_too_long),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  dns_query_builder_unit_checker #(.MAX_LABEL(MAX_LABEL)) msg_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_name_char       (in_name_char),
    .in_name_end        (in_name_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_packet_last    (out_packet_last),
    .out_label_too_long (out_label_too_long),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .error_count        (error_count),
    .bytes_pending      (bytes_pending),
    .bytes_checked      (bytes_checked),
    .labels_cut         (labels_cut)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    #2_000_000;
    $display("dns_query_builder_unit_tb: done, errors");
    $finish;
  end

  // Any byte but the separator.
  function automatic logic [7:0] label_char();
    int c;
    c = $urandom_range(0, 254);
    if (c >= dqb_pkg::DOT_CHAR) c++;
    return 8'(c);
  endfunction

  function automatic void add_label(input int len);
    for (int i = 0; i < len; i++) name_q.push_back(label_char());
  endfunction

  // Starts and ends on a falling edge except the last wait, which ends at the accepting edge.
  task automatic send_char(input logic [7:0] ch, input logic name_last);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_name_char <= ch;
    in_name_end  <= name_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_name();
    for (int i = 0; i < name_q.size(); i++) send_char(name_q[i], i == name_q.size() - 1);
    names_sent++;
  endtask

  task automatic random_name();
    int n_labels;
    name_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      // noise: raw bytes, separators included
      repeat ($urandom_range(1, 6)) name_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      n_labels = $urandom_range(1, 4);
      for (int l = 0; l < n_labels; l++) begin
        if (l > 0) name_q.push_back(dqb_pkg::DOT_CHAR);
        if ($urandom_range(0, 11) == 0) add_label($urandom_range(MAX_LABEL - 2, MAX_LABEL + 4));
        else add_label($urandom_range(0, 6));
      end
      if ($urandom_range(0, 3) == 0 || name_q.size() == 0) name_q.push_back(dqb_pkg::DOT_CHAR);
    end
    send_name();
  endtask

  task automatic random_names(input int n_chars);
    int first;
    first = chars_sent;
    while (chars_sent - first < n_chars) random_name();
  endtask

  // Drop valid, wait for every predicted byte, then let a trailing item settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (bytes_pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Called on a falling edge with the block idle.
  task automatic program_regs(input logic [15:0] qid, input logic [15:0] qtype);
    cfg_we    <= 1'b1;
    cfg_index <= dqb_pkg::CFG_QUERY_ID;
    cfg_wdata <= qid;
    @(negedge clk);
    cfg_index <= dqb_pkg::CFG_QTYPE;
    cfg_wdata <= qtype;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_name_char   = 8'h00;
    in_name_end    = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = dqb_pkg::CFG_QUERY_ID;
    cfg_wdata      = 16'h0000;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    chars_sent     = 0;
    names_sent     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed names under reset register values, no idling.
    name_q = '{dqb_pkg::DOT_CHAR};                             // lone dot
    send_name();
    name_q = '{8'h61, dqb_pkg::DOT_CHAR};                      // final dot
    send_name();
    name_q = '{8'h00, dqb_pkg::DOT_CHAR, 8'hFF};               // extreme characters
    send_name();
    name_q = '{8'h61, dqb_pkg::DOT_CHAR, dqb_pkg::DOT_CHAR, 8'h62};  // empty label inside
    send_name();
    name_q = '{dqb_pkg::DOT_CHAR, 8'h78};                      // leading empty label
    send_name();
    name_q = '{8'h7A};                                         // single character
    send_name();
    name_q.delete();                                           // label one past the limit
    add_label(MAX_LABEL + 1);
    send_name();
    drain();

    program_regs(16'hFFFF, 16'hFFFF);
    random_names(10);
    drain();

    send_idle_pct = 83;
    program_regs(16'h0000, 16'h0000);
    random_names(10);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 83;
    program_regs(16'($urandom), 16'($urandom));
    random_names(10);
    drain();

    send_idle_pct  = 23;
    recv_stall_pct = 23;
    program_regs(16'($urandom), 16'h0001);
    random_names(10);
    drain();

    $display("dns_query_builder_unit_tb: %0d characters in %0d names, %0d bytes compared",
             chars_sent, names_sent, bytes_checked);
    $display("dns_query_builder_unit_tb: %0d truncated labels, 5 register settings, 4 idle modes",
             labels_cut);
    if (error_count == 0 && bytes_pending == 0) begin
      $display("dns_query_builder_unit_tb: done, clean");
    end else begin
      $display("dns_query_builder_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
